>>> design/vct_pkg.sv
package vct_pkg;

   // Fixed field widths of the request, result and register ports.
   localparam int TAG_W        = 8;
   localparam int TAG_SPAN     = 1 << TAG_W;
   localparam int CFG_W        = 8;
   localparam int STATUS_W     = 2;
   localparam int PASS_COUNT_W = 8;

   // Entry status codes, as stored in the table and reported on the result.
   typedef enum logic [STATUS_W-1:0] {
      ST_PENDING  = 2'd0,
      ST_PASSED   = 2'd1,
      ST_REJECTED = 2'd2
   } status_type;

   // Request mode codes.
   typedef enum logic {
      MODE_VOTE  = 1'b0,
      MODE_ERASE = 1'b1
   } mode_type;

   // Vote values.
   localparam logic VOTE_FAIL = 1'b0;
   localparam logic VOTE_PASS = 1'b1;

endpackage

>>> design/vote_completion_tracker.sv
// Vote completion tracker. Each request names a tag and either records a pass or fail
// vote for that tag's entry or erases the entry; every request returns exactly one result
// with the entry's status and pass count after the request. The entries live in a single
// synchronous RAM of TAG_COUNT words with one read and one write port. A request is read
// at the edge it is accepted, updated in the second stage and written back, and its
// result is registered as it is written back. A request can be accepted in every cycle
// unless the second stage is held by a stalled result register or the sweep runs: a
// back-to-back request to the same entry takes the just-computed entry from a bypass
// register instead of the RAM. After reset the block sweeps the RAM to empty entries, one
// entry a cycle, and holds req_stall high until the sweep is done. The required_votes
// register is written through the csr_ port, which is always ready; it should only be
// written while no request is in flight.
module vote_completion_tracker
   import vct_pkg::*;
#(
   parameter int TAG_COUNT  = 256,
   parameter int COUNT_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel.
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_mode,
   input  logic [TAG_W-1:0]        req_tag,
   input  logic                    req_vote,
   // Result channel.
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [PASS_COUNT_W-1:0] rsp_pass_count,
   // Register write channel.
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CFG_W-1:0]        csr_required_votes
);

   localparam int SLOT_W  = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
   localparam int ENTRY_W = STATUS_W + COUNT_BITS;
   localparam int CMP_W   = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(TAG_COUNT - 1);

   // Tracker RAM.
   logic [ENTRY_W-1:0] table_mem [TAG_COUNT];

   // Tag to slot reduction, a constant table over every tag value.
   logic [SLOT_W-1:0] slot_lut [TAG_SPAN];
   for (genvar g = 0; g < TAG_SPAN; g++) begin : g_slot_lut
      assign slot_lut[g] = SLOT_W'(g % TAG_COUNT);
   end

   logic [CFG_W-1:0]      required_votes_ff, required_votes_in;
   logic                  clearing_ff, clearing_in;
   logic [SLOT_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [SLOT_W-1:0]     s1_slot_ff;
   logic                  s1_mode_ff;
   logic                  s1_vote_ff;
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic                  fwd_hit_ff;
   logic [ENTRY_W-1:0]    fwd_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [PASS_COUNT_W-1:0] rsp_pass_count_ff;

   logic                  req_accept;
   logic                  out_free;
   logic                  s1_fire;
   logic [SLOT_W-1:0]     req_slot;
   logic [ENTRY_W-1:0]    old_entry;
   status_type            old_status;
   logic [COUNT_BITS-1:0] old_count;
   logic [COUNT_BITS-1:0] inc_count;
   logic [CFG_W-1:0]      need_votes;
   status_type            new_status;
   logic [COUNT_BITS-1:0] new_count;
   logic [ENTRY_W-1:0]    new_entry;
   logic [CMP_W-1:0]      new_count_ext;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_waddr;
   logic [ENTRY_W-1:0]    mem_wdata;

   // Handshake control.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_stall  = clearing_ff || (s1_valid_ff && !out_free);
   assign req_accept = req_valid && !req_stall;
   assign req_slot   = slot_lut[req_tag];
   assign csr_ready  = 1'b1;

   // Configuration register.
   always_comb begin
      required_votes_in = required_votes_ff;
      if (csr_valid && csr_ready) begin
         required_votes_in = csr_required_votes;
      end
   end

   // Clearing sweep after reset.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + SLOT_W'(1);
         if (clr_addr_ff == LAST_SLOT) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Entry update for the request in the second stage.
   always_comb begin
      old_entry  = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      old_status = status_type'(old_entry[ENTRY_W-1 -: STATUS_W]);
      old_count  = old_entry[COUNT_BITS-1:0];
      need_votes = (required_votes_ff == '0) ? CFG_W'(1) : required_votes_ff;
      inc_count  = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_BITS'(1);
      new_status = old_status;
      new_count  = old_count;
      if (s1_mode_ff == MODE_ERASE) begin
         new_status = ST_PENDING;
         new_count  = '0;
      end else if (old_status == ST_PENDING) begin
         if (s1_vote_ff == VOTE_FAIL) begin
            new_status = ST_REJECTED;
            new_count  = '0;
         end else if (CMP_W'(inc_count) >= CMP_W'(need_votes)) begin
            new_status = ST_PASSED;
            new_count  = '0;
         end else begin
            new_count  = inc_count;
         end
      end
      new_entry     = {new_status, new_count};
      new_count_ext = CMP_W'(new_count);
   end

   // RAM write port: the clearing sweep or the write-back.
   always_comb begin
      mem_we    = clearing_ff || s1_fire;
      mem_waddr = clearing_ff ? clr_addr_ff : s1_slot_ff;
      mem_wdata = clearing_ff ? {ST_PENDING, {COUNT_BITS{1'b0}}} : new_entry;
   end

   // Tracker RAM, read-before-write on the same address.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         rd_data_ff <= table_mem[req_slot];
      end
   end

   // Stage and result valid next values.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         required_votes_ff <= CFG_W'(1);
         clearing_ff       <= 1'b1;
         clr_addr_ff       <= '0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         required_votes_ff <= required_votes_in;
         clearing_ff       <= clearing_in;
         clr_addr_ff       <= clr_addr_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Second-stage payload and the same-entry bypass.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_slot_ff  <= req_slot;
         s1_mode_ff  <= req_mode;
         s1_vote_ff  <= req_vote;
         fwd_hit_ff  <= s1_fire && (s1_slot_ff == req_slot);
         fwd_data_ff <= new_entry;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_status_ff     <= new_status;
         rsp_pass_count_ff <= new_count_ext[PASS_COUNT_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pass_count = rsp_pass_count_ff;

endmodule

>>> design/vct_checker.sv
module vct_checker
   import vct_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic [PASS_COUNT_W-1:0] rsp_pass_count
);

   // A stalled request stays offered.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("request withdrawn while stalled");

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_pass_count))
      else $error("result payload changed while stalled");

   // The table sweep after reset holds off requests.
   assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during the table sweep");

   // A decided entry always reports a zero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_PENDING) |-> rsp_pass_count == '0)
      else $error("decided entry reported a nonzero count");

endmodule

bind vote_completion_tracker vct_checker u_vct_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_pass_count (rsp_pass_count)
);

>>> test/testbench.sv
module testbench
   import vct_pkg::*;
();

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int PHASE_REQUESTS  = 105;
   localparam int DIRECTED_COUNT  = 17;

   typedef struct packed {
      mode_type         mode;
      logic [TAG_W-1:0] tag;
      logic             vote;
   } vote_req_type;

   typedef struct packed {
      status_type                status;
      logic [PASS_COUNT_W-1:0]   pass_count;
   } tally_type;

   typedef struct packed {
      logic             set_cfg;
      logic [CFG_W-1:0] cfg_value;
      vote_req_type     rq;
      logic             checked;
      tally_type        golden;
   } directed_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_mode;
   logic [TAG_W-1:0]        req_tag;
   logic                    req_vote;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [PASS_COUNT_W-1:0] rsp_pass_count;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CFG_W-1:0]        csr_required_votes;

   // Local copy of the tracker table and the threshold register.
   status_type              track_status [TAG_SPAN];
   logic [PASS_COUNT_W-1:0] track_count [TAG_SPAN];
   logic [CFG_W-1:0]        votes_needed;

   tally_type        expected_tallies [$];
   directed_row_type directed_rows [DIRECTED_COUNT];
   int               mismatch_count = 0;
   int               burst_left = 0;
   int               idle_cycles = 0;
   int               hold_left = 0;
   int               stall_cycle = 0;
   bit               hold_pending = 1'b0;
   bit               hold_started = 1'b0;

   vote_completion_tracker i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_tag            (req_tag),
      .req_vote           (req_vote),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_pass_count     (rsp_pass_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_required_votes (csr_required_votes)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one request to the local table and return the entry after it.
   function automatic tally_type tally_request(input vote_req_type rq);
      tally_type               outcome;
      logic [PASS_COUNT_W-1:0] count;
      logic [CFG_W-1:0]        need;
      need = (votes_needed == '0) ? CFG_W'(1) : votes_needed;
      count = track_count[rq.tag];
      if (rq.mode == MODE_ERASE) begin
         track_status[rq.tag] = ST_PENDING;
         track_count[rq.tag] = '0;
      end else if (track_status[rq.tag] == ST_PENDING) begin
         if (rq.vote == VOTE_FAIL) begin
            track_status[rq.tag] = ST_REJECTED;
            track_count[rq.tag] = '0;
         end else begin
            // The count saturates rather than wrapping.
            if (count != '1) begin
               count = count + 1'b1;
            end
            if (count >= need) begin
               track_status[rq.tag] = ST_PASSED;
               count = '0;
            end
            track_count[rq.tag] = count;
         end
      end
      outcome.status = track_status[rq.tag];
      outcome.pass_count = (outcome.status == ST_PENDING) ? track_count[rq.tag] : '0;
      return outcome;
   endfunction

   // Offer one request, wait for it to be taken, then pace the next one.
   task automatic send_request(input vote_req_type rq, input bit has_golden,
                               input tally_type golden);
      tally_type predicted;
      int        gap;
      req_valid <= 1'b1;
      req_mode <= rq.mode;
      req_tag <= rq.tag;
      req_vote <= rq.vote;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = tally_request(rq);
      if (has_golden) begin
         predicted = golden;
      end
      expected_tallies = {expected_tallies, predicted};
      // Bursts of back-to-back requests separated by random gaps.
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end else begin
         burst_left--;
      end
   endtask

   // Stop offering and wait until every outstanding result has come back.
   task automatic drain_requests();
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      @(posedge clock);
      while (expected_tallies.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_required_votes(input logic [CFG_W-1:0] value);
      drain_requests();
      csr_valid <= 1'b1;
      csr_required_votes <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      votes_needed = value;
      csr_valid <= 1'b0;
   endtask

   // Mostly votes on a few hot tags so entries get decided, plus noise.
   function automatic vote_req_type pick_request(input logic [TAG_W-1:0] hot_tags [4]);
      vote_req_type rq;
      int           roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         rq.mode = MODE_VOTE;
         rq.tag = hot_tags[$urandom_range(0, 3)];
         rq.vote = ($urandom_range(0, 99) < 88) ? VOTE_PASS : VOTE_FAIL;
      end else if (roll < 80) begin
         rq.mode = MODE_ERASE;
         rq.tag = hot_tags[$urandom_range(0, 3)];
         rq.vote = 1'($urandom_range(0, 1));
      end else begin
         rq.mode = mode_type'($urandom_range(0, 1));
         rq.tag = TAG_W'($urandom_range(0, TAG_SPAN - 1));
         rq.vote = 1'($urandom_range(0, 1));
      end
      return rq;
   endfunction

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      tally_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tallies.size() == 0) begin
            $error("unexpected result: status %0d, pass_count %0d", rsp_status,
                   rsp_pass_count);
            mismatch_count++;
         end else begin
            want = expected_tallies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_pass_count !== want.pass_count) begin
               $error("pass_count mismatch: expected %0d, actual %0d", want.pass_count,
                      rsp_pass_count);
               mismatch_count++;
            end
         end
      end
   end

   // Result stalls: a pattern that steps through four styles in turn,
   // overridden by one long hold-off when the stimulus asks for it.
   always @(posedge clock) begin
      stall_cycle++;
      if (hold_pending && !hold_started) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_started = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case ((stall_cycle / 400) % 4)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 99) < 25);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 99) < 70);
            end
            default: begin
               rsp_stall <= ((stall_cycle % 5) < 2);
            end
         endcase
      end
   end

   // Watchdog: end the run when no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles, %0d results outstanding", idle_cycles,
                   expected_tallies.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      vote_req_type     rq;
      tally_type        no_golden;
      logic [TAG_W-1:0] hot_tags [4];
      logic [TAG_W-1:0] deep_tag;
      int               phase_votes [9];

      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_VOTE;
      req_tag = '0;
      req_vote = VOTE_FAIL;
      csr_valid = 1'b0;
      csr_required_votes = '0;
      no_golden = '0;
      votes_needed = 8'd1;
      for (int i = 0; i < TAG_SPAN; i++) begin
         track_status[i] = ST_PENDING;
         track_count[i] = '0;
      end

      // Directed table: threshold change, then one request, golden where obvious.
      directed_rows = '{
         '{1'b0, 8'd0,   '{MODE_VOTE,  8'h00, VOTE_PASS}, 1'b1, '{ST_PASSED,   8'd0}},
         '{1'b0, 8'd0,   '{MODE_VOTE,  8'h00, VOTE_PASS}, 1'b1, '{ST_PASSED,   8'd0}},
         '{1'b0, 8'd0,   '{MODE_VOTE,  8'h00, VOTE_FAIL}, 1'b1, '{ST_PASSED,   8'd0}},
         '{1'b0, 8'd0,   '{MODE_ERASE, 8'h00, VOTE_FAIL}, 1'b1, '{ST_PENDING,  8'd0}},
         '{1'b0, 8'd0,   '{MODE_VOTE,  8'hFF, VOTE_FAIL}, 1'b1, '{ST_REJECTED, 8'd0}},
         '{1'b0, 8'd0,   '{MODE_VOTE,  8'hFF, VOTE_PASS}, 1'b1, '{ST_REJECTED, 8'd0}},
         '{1'b0, 8'd0,   '{MODE_ERASE, 8'hFF, VOTE_PASS}, 1'b1, '{ST_PENDING,  8'd0}},
         // A threshold of zero acts as one.
         '{1'b1, 8'd0,   '{MODE_VOTE,  8'h01, VOTE_PASS}, 1'b1, '{ST_PASSED,   8'd0}},
         '{1'b1, 8'd3,   '{MODE_VOTE,  8'h02, VOTE_PASS}, 1'b1, '{ST_PENDING,  8'd1}},
         '{1'b0, 8'd0,   '{MODE_VOTE,  8'h02, VOTE_PASS}, 1'b1, '{ST_PENDING,  8'd2}},
         // Threshold lowered while the entry is part way through counting.
         '{1'b1, 8'd2,   '{MODE_VOTE,  8'h02, VOTE_PASS}, 1'b1, '{ST_PASSED,   8'd0}},
         '{1'b1, 8'd255, '{MODE_VOTE,  8'hAA, VOTE_PASS}, 1'b0, '{ST_PENDING,  8'd0}},
         '{1'b0, 8'd0,   '{MODE_VOTE,  8'h55, VOTE_PASS}, 1'b1, '{ST_PENDING,  8'd1}},
         '{1'b0, 8'd0,   '{MODE_VOTE,  8'hAA, VOTE_PASS}, 1'b0, '{ST_PENDING,  8'd0}},
         '{1'b0, 8'd0,   '{MODE_VOTE,  8'hAA, VOTE_FAIL}, 1'b1, '{ST_REJECTED, 8'd0}},
         '{1'b0, 8'd0,   '{MODE_ERASE, 8'hAA, VOTE_PASS}, 1'b1, '{ST_PENDING,  8'd0}},
         '{1'b1, 8'd1,   '{MODE_VOTE,  8'h55, VOTE_PASS}, 1'b0, '{ST_PENDING,  8'd0}}
      };
      phase_votes = '{1, 2, 0, 3, 5, 8, 1, 4, 2};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (directed_rows[i].set_cfg) begin
            set_required_votes(directed_rows[i].cfg_value);
         end
         send_request(directed_rows[i].rq, directed_rows[i].checked,
                      directed_rows[i].golden);
      end

      // Random phases, each with its own threshold and set of hot tags.
      for (int p = 0; p < 9; p++) begin
         set_required_votes(CFG_W'(phase_votes[p]));
         for (int k = 0; k < 4; k++) begin
            hot_tags[k] = TAG_W'($urandom_range(0, TAG_SPAN - 1));
         end
         // Hold off results for a long stretch so the pipeline backs up.
         if (p == 4) begin
            hold_pending = 1'b1;
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            send_request(pick_request(hot_tags), 1'b0, no_golden);
         end
      end

      // Highest threshold: count one entry all the way up until it passes.
      set_required_votes(8'd255);
      deep_tag = TAG_W'($urandom_range(0, TAG_SPAN - 1));
      rq = '{MODE_ERASE, deep_tag, VOTE_PASS};
      send_request(rq, 1'b0, no_golden);
      rq.mode = MODE_VOTE;
      for (int n = 0; n < 255; n++) begin
         send_request(rq, 1'b0, no_golden);
      end
      rq.vote = VOTE_FAIL;
      send_request(rq, 1'b0, no_golden);
      for (int k = 0; k < 4; k++) begin
         hot_tags[k] = TAG_W'($urandom_range(0, TAG_SPAN - 1));
      end
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
         send_request(pick_request(hot_tags), 1'b0, no_golden);
      end

      drain_requests();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
